// ----- rtl/rvh_pkg.sv -----
// ----------------------------------------------------------------------------
// rvh_pkg
// Shared widths, command codes and register indexes of the histogram engine.
// ----------------------------------------------------------------------------
package rvh_pkg;

  // Default sizing of the bin store and of the sample word.
  localparam int MAX_BINS_DEF   = 64;
  localparam int VALUE_BITS_DEF = 31;

  // Field widths of the request and result channels.
  localparam int CMD_W     = 2;
  localparam int SAMPLE_W  = 31;
  localparam int BIN_NUM_W = 6;
  localparam int TOTAL_W   = 32;

  // Configuration port.
  localparam int BIN_COUNT_W = 7;
  localparam int APB_ADDR_W  = 3;
  localparam int APB_DATA_W  = 32;

  // Register indexes, taken from address bit 2.
  localparam logic REG_BIN_COUNT = 1'b0;
  localparam logic REG_BIN_MODE  = 1'b1;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_ADD   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DUMP  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

  // Binning methods.
  localparam logic MODE_REMAINDER = 1'b0;
  localparam logic MODE_QUOTIENT  = 1'b1;

  // Remainder unit retires this many sample bits per cycle.
  localparam int REM_BITS_PER_CYCLE = 4;

  // Saturation value of a bin counter.
  localparam logic [TOTAL_W-1:0] COUNT_MAX = '1;

endpackage

// ----- rtl/rvh_in_if.sv -----
// ----------------------------------------------------------------------------
// rvh_in_if
// Request channel: command and sample value with valid/ready handshake.
// ----------------------------------------------------------------------------
interface rvh_in_if;
  logic                        valid;
  logic                        ready;
  logic [rvh_pkg::CMD_W-1:0]    cmd;
  logic [rvh_pkg::SAMPLE_W-1:0] sample_value;

  modport source (output valid, output cmd, output sample_value, input ready);
  modport sink   (input valid, input cmd, input sample_value, output ready);
endinterface

// ----- rtl/rvh_out_if.sv -----
// ----------------------------------------------------------------------------
// rvh_out_if
// Result channel: the bins reported by a dump request, with valid/ready handshake.
// ----------------------------------------------------------------------------
interface rvh_out_if;
  logic                         valid;
  logic                         ready;
  logic [rvh_pkg::BIN_NUM_W-1:0] bin_number;
  logic [rvh_pkg::TOTAL_W-1:0]   bin_total;
  logic                         last_bin;

  modport source (output valid, output bin_number, output bin_total, output last_bin,
                  input ready);
  modport sink   (input valid, input bin_number, input bin_total, input last_bin,
                  output ready);
endinterface

// ----- rtl/random_value_histogram_core.sv -----
// ----------------------------------------------------------------------------
// random_value_histogram_core
// Histogram engine: bins random samples, dumps and clears a counter memory.
// ----------------------------------------------------------------------------
// Usage. Requests enter on in_ch: an add places sample_value in a bin and
// bumps that bin's saturating counter, a dump reports every bin in use on
// out_ch in ascending order with last_bin on the final one, a clear zeroes
// all counters. Code 3 is dropped. The user must write bin_count and bin_mode
// over the APB port only while the engine is idle; the core doesn't enforce it.
// Sequencing. An add in remainder mode runs the remainder unit, which retires
// four sample bits per cycle, and then a memory read-modify-write; in quotient
// mode a scale step replaces the remainder unit. A dump does one memory read
// and one output load per bin. A clear takes effect when it is accepted.
// Each dump result passes the registered memory read, then the output register.
// Reset. Per-bin valid flags clear at once, so all counts read as zero
// right after reset; there is no clearing pass.
// Stalls. Results sit in an output register; a dump waits while it is full and
// not taken, and takes no requests meanwhile; other requests are taken once idle.
// ----------------------------------------------------------------------------
module random_value_histogram_core #(
  parameter int MAX_BINS   = rvh_pkg::MAX_BINS_DEF,
  parameter int VALUE_BITS = rvh_pkg::VALUE_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [rvh_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [rvh_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [rvh_pkg::APB_DATA_W-1:0]   prdata,
  output logic                             pready,
  rvh_in_if.sink                           in_ch,
  rvh_out_if.source                        out_ch
);

  localparam int BIN_W      = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
  localparam int N_W        = $clog2(MAX_BINS + 1);
  localparam int RB         = rvh_pkg::REM_BITS_PER_CYCLE;
  localparam int DIV_CYCLES = (VALUE_BITS + RB - 1) / RB;
  localparam int SR_W       = DIV_CYCLES * RB;
  localparam int DC_W       = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;
  localparam int PROD_W     = N_W + VALUE_BITS;
  localparam int TW         = rvh_pkg::TOTAL_W;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_DIV   = 6'b000010,
    S_SCALE = 6'b000100,
    S_UPD   = 6'b001000,
    S_DRD   = 6'b010000,
    S_DOUT  = 6'b100000
  } state_t;

  state_t state;

  // Configuration registers.
  logic [rvh_pkg::BIN_COUNT_W-1:0] bin_count;
  logic                            bin_mode;

  // Sample datapath.
  logic [VALUE_BITS-1:0] val_q;
  logic [SR_W-1:0]       div_sr;
  logic [N_W-1:0]        rem;
  logic [DC_W-1:0]       div_cnt;
  logic [BIN_W-1:0]      upd_addr;
  logic [BIN_W-1:0]      dump_idx;

  // Bin store.
  logic [TW-1:0]       mem [MAX_BINS];
  logic [TW-1:0]       mem_rdata;
  logic                rd_valid;
  logic [MAX_BINS-1:0] bin_valid;
  logic                mem_re;
  logic [BIN_W-1:0]    mem_raddr;
  logic                mem_we;
  logic [TW-1:0]       mem_wdata;

  // Output register.
  logic                          out_vld;
  logic [rvh_pkg::BIN_NUM_W-1:0] out_bin;
  logic [TW-1:0]                 out_total;
  logic                          out_last;
  logic                          out_load;

  logic                  in_acc;
  logic [N_W-1:0]        n;
  logic [31:0]           samp32;
  logic [VALUE_BITS-1:0] v_in;
  logic [N_W-1:0]        rem_step;
  logic [PROD_W-1:0]     prod;
  logic [N_W-1:0]        quot;
  logic [BIN_W-1:0]      quot_bin;
  logic [TW-1:0]         cur_count;
  logic                  dump_last;

  // APB access: register index from address bit 2, always ready.
  assign pready = 1'b1;

  always_comb begin
    case (paddr[2])
      rvh_pkg::REG_BIN_COUNT: prdata = rvh_pkg::APB_DATA_W'(bin_count);
      rvh_pkg::REG_BIN_MODE:  prdata = rvh_pkg::APB_DATA_W'(bin_mode);
      default:                prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bin_count <= rvh_pkg::BIN_COUNT_W'(MAX_BINS);
      bin_mode  <= rvh_pkg::MODE_REMAINDER;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[2])
        rvh_pkg::REG_BIN_COUNT: bin_count <= pwdata[rvh_pkg::BIN_COUNT_W-1:0];
        rvh_pkg::REG_BIN_MODE:  bin_mode  <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Bins in use: zero acts as one, large counts clip to the store depth.
  always_comb begin
    if (bin_count == '0) begin
      n = N_W'(1);
    end else if (bin_count > rvh_pkg::BIN_COUNT_W'(MAX_BINS)) begin
      n = N_W'(MAX_BINS);
    end else begin
      n = bin_count[N_W-1:0];
    end
  end

  assign in_ch.ready = (state == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign samp32      = 32'(in_ch.sample_value);
  assign v_in        = samp32[VALUE_BITS-1:0];

  // Remainder unit: four restoring steps per cycle, MSB first.
  always_comb begin
    logic [N_W:0] t;
    rem_step = rem;
    for (int k = 0; k < RB; k++) begin
      t = {rem_step, div_sr[SR_W-1-k]};
      if (t >= {1'b0, n}) begin
        t = t - {1'b0, n};
      end
      rem_step = t[N_W-1:0];
    end
  end

  // Quotient method: (n * value) >> VALUE_BITS, clipped below n.
  assign prod = PROD_W'(n) * PROD_W'(val_q);

  always_comb begin
    quot = prod[VALUE_BITS +: N_W];
    if (quot >= n) begin
      quot = n - N_W'(1);
    end
    quot_bin = quot[BIN_W-1:0];
  end

  // Read-modify-write of the selected bin, saturating at full scale.
  assign cur_count = rd_valid ? mem_rdata : '0;
  assign mem_we    = (state == S_UPD);
  assign mem_wdata = (cur_count == rvh_pkg::COUNT_MAX) ? cur_count : cur_count + TW'(1);
  assign dump_last = ({1'b0, dump_idx} == (BIN_W + 1)'(n - N_W'(1)));
  assign out_load  = (state == S_DOUT) && (!out_vld || out_ch.ready);

  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = dump_idx;
    case (state)
      S_DIV: begin
        mem_re    = (div_cnt == '0);
        mem_raddr = rem_step[BIN_W-1:0];
      end
      S_SCALE: begin
        mem_re    = 1'b1;
        mem_raddr = quot_bin;
      end
      S_DRD: begin
        mem_re    = 1'b1;
        mem_raddr = dump_idx;
      end
      default: ;
    endcase
  end

  // Control sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            if (in_ch.cmd == rvh_pkg::CMD_ADD) begin
              state <= (bin_mode == rvh_pkg::MODE_QUOTIENT) ? S_SCALE : S_DIV;
            end else if (in_ch.cmd == rvh_pkg::CMD_DUMP) begin
              state <= S_DRD;
            end
          end
        end
        S_DIV: begin
          if (div_cnt == '0) begin
            state <= S_UPD;
          end
        end
        S_SCALE: state <= S_UPD;
        S_UPD:   state <= S_IDLE;
        S_DRD:   state <= S_DOUT;
        S_DOUT: begin
          if (out_load) begin
            state <= dump_last ? S_IDLE : S_DRD;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath registers of the sample and dump sequences.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        val_q    <= v_in;
        div_sr   <= SR_W'(v_in);
        rem      <= '0;
        div_cnt  <= DC_W'(DIV_CYCLES - 1);
        dump_idx <= '0;
      end
      S_DIV: begin
        div_sr   <= div_sr << RB;
        rem      <= rem_step;
        div_cnt  <= div_cnt - DC_W'(1);
        upd_addr <= rem_step[BIN_W-1:0];
      end
      S_SCALE: upd_addr <= quot_bin;
      S_DOUT: begin
        if (out_load) begin
          dump_idx <= dump_idx + BIN_W'(1);
        end
      end
      default: ;
    endcase
  end

  // Counter memory with registered read.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[upd_addr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata <= mem[mem_raddr];
      rd_valid  <= bin_valid[mem_raddr];
    end
  end

  // Per-bin valid flags: reset and clear requests zero every bin at once.
  always_ff @(posedge clk) begin
    if (rst) begin
      bin_valid <= '0;
    end else if (in_acc && in_ch.cmd == rvh_pkg::CMD_CLEAR) begin
      bin_valid <= '0;
    end else if (mem_we) begin
      bin_valid[upd_addr] <= 1'b1;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (out_load) begin
      out_vld <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_bin   <= rvh_pkg::BIN_NUM_W'(dump_idx);
      out_total <= cur_count;
      out_last  <= dump_last;
    end
  end

  assign out_ch.valid      = out_vld;
  assign out_ch.bin_number = out_bin;
  assign out_ch.bin_total  = out_total;
  assign out_ch.last_bin   = out_last;

`ifndef ASSERT_OFF
  // A quotient-mode add writes its bin in S_UPD, after the S_SCALE state.
  a_scale_write: assert property (@(posedge clk) disable iff (rst)
    (in_acc && in_ch.cmd == rvh_pkg::CMD_ADD && bin_mode == rvh_pkg::MODE_QUOTIENT)
      |=> ##1 mem_we)
    else $error("quotient add did not write its bin");

  // A counter write-back never stores zero.
  a_wdata_nonzero: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (mem_wdata != '0))
    else $error("counter write-back of zero");

  // A clear request leaves every bin invalid.
  a_clear: assert property (@(posedge clk) disable iff (rst)
    (in_acc && in_ch.cmd == rvh_pkg::CMD_CLEAR) |=> (bin_valid == '0))
    else $error("clear left a bin valid");

  // The final bin of a dump returns the sequencer to idle.
  a_dump_end: assert property (@(posedge clk) disable iff (rst)
    (out_load && dump_last) |=> (state == S_IDLE))
    else $error("dump did not end after the final bin");

  // A reported bin lies within the bins in use.
  a_bin_range: assert property (@(posedge clk) disable iff (rst)
    out_vld |-> ((BIN_W + 1)'(out_bin) < (BIN_W + 1)'(n)))
    else $error("reported bin beyond the bins in use");
`endif

endmodule
